>>> design/owned_refcounted_handle_pool_defines.svh
// assertion macros for the handle pool
`ifndef OWNED_REFCOUNTED_HANDLE_POOL_DEFINES_SVH
`define OWNED_REFCOUNTED_HANDLE_POOL_DEFINES_SVH

// same-cycle implication, held off during reset
`define ORHP_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("orhp check failed");

// next-cycle implication, held off during reset
`define ORHP_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("orhp check failed");

`endif

>>> design/orhp_pkg.sv
// types, codes and defaults shared by the handle pool
package orhp_pkg;

    localparam int POOL_SLOTS_DEF = 64;
    localparam int POOL_KINDS_DEF = 5;

    localparam logic [2:0] CMD_LOOKUP   = 3'd0;
    localparam logic [2:0] CMD_ALLOC    = 3'd1;
    localparam logic [2:0] CMD_ADD_REF  = 3'd2;
    localparam logic [2:0] CMD_DROP_REF = 3'd3;
    localparam logic [2:0] CMD_OWN_REL  = 3'd4;
    localparam logic [2:0] CMD_FORCE    = 3'd5;
    localparam logic [2:0] CMD_TEARDOWN = 3'd6;
    localparam logic [2:0] CMD_UNKNOWN  = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RANGE     = 3'd1;
    localparam logic [2:0] ST_NOT_LIVE  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_ARG   = 3'd4;
    localparam logic [2:0] ST_NOT_OWNER = 3'd5;
    localparam logic [2:0] ST_SATURATED = 3'd6;

    localparam logic [2:0] KIND_SEM     = 3'd2;
    localparam logic [2:0] KIND_BARRIER = 3'd3;

    localparam logic [15:0] REFS_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]         command;
        logic [2:0]         pool_kind;
        logic signed [7:0]  handle;
        logic [15:0]        owner_id;
        logic [31:0]        owner_epoch;
        logic signed [31:0] alloc_arg;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  handle_out;
        logic [15:0] ref_count;
    } t_out_item;

    typedef struct packed {
        logic        live;
        logic [15:0] owner;
        logic [31:0] gen;
        logic [15:0] refs;
    } t_slot;

    typedef struct packed {
        logic        wr;
        logic [2:0]  status;
        logic [15:0] refs;
        t_slot       nxt;
    } t_rule;

endpackage

>>> design/orhp_rule.sv
// per-slot command rules: new entry, status and count for one slot
module orhp_rule (
    input  logic [2:0]    i_command,
    input  logic [15:0]   i_who,
    input  logic [31:0]   i_gen,
    input  orhp_pkg::t_slot i_entry,
    output orhp_pkg::t_rule o_rule
);

    logic    match;
    orhp_pkg::t_slot freed;

    assign match = (i_entry.owner == 16'd0 && i_who == 16'd0) ||
                   (i_who != 16'd0 && i_entry.owner == i_who && i_entry.gen == i_gen);

    always_comb begin
        freed       = i_entry;
        freed.live  = 1'b0;
        freed.owner = 16'd0;
    end

    always_comb begin
        o_rule.wr     = 1'b0;
        o_rule.status = orhp_pkg::ST_OK;
        o_rule.refs   = i_entry.refs;
        o_rule.nxt    = i_entry;
        case (i_command)
            orhp_pkg::CMD_LOOKUP: begin
                if (!i_entry.live) o_rule.status = orhp_pkg::ST_NOT_LIVE;
            end
            orhp_pkg::CMD_ALLOC: begin
                o_rule.wr        = !i_entry.live;
                o_rule.nxt.live  = 1'b1;
                o_rule.nxt.owner = i_who;
                o_rule.nxt.gen   = (i_who != 16'd0) ? i_gen : 32'd0;
                o_rule.nxt.refs  = 16'd1;
                o_rule.refs      = 16'd1;
            end
            orhp_pkg::CMD_ADD_REF: begin
                if (!i_entry.live) begin
                    o_rule.status = orhp_pkg::ST_NOT_LIVE;
                end else if (i_entry.refs == orhp_pkg::REFS_MAX) begin
                    o_rule.status = orhp_pkg::ST_SATURATED;
                end else begin
                    o_rule.wr       = 1'b1;
                    o_rule.nxt.refs = i_entry.refs + 16'd1;
                    o_rule.refs     = i_entry.refs + 16'd1;
                end
            end
            orhp_pkg::CMD_DROP_REF: begin
                if (!i_entry.live) begin
                    o_rule.status = orhp_pkg::ST_NOT_LIVE;
                end else if (i_entry.refs <= 16'd1) begin
                    o_rule.wr       = 1'b1;
                    o_rule.nxt      = freed;
                    o_rule.nxt.refs = 16'd0;
                    o_rule.refs     = 16'd0;
                end else begin
                    o_rule.wr       = 1'b1;
                    o_rule.nxt.refs = i_entry.refs - 16'd1;
                    o_rule.refs     = i_entry.refs - 16'd1;
                end
            end
            orhp_pkg::CMD_OWN_REL: begin
                if (!i_entry.live) begin
                    o_rule.status = orhp_pkg::ST_NOT_LIVE;
                end else if (!match) begin
                    o_rule.status = orhp_pkg::ST_NOT_OWNER;
                end else begin
                    o_rule.wr  = 1'b1;
                    o_rule.nxt = freed;
                end
            end
            orhp_pkg::CMD_FORCE: begin
                o_rule.wr       = 1'b1;
                o_rule.nxt      = freed;
                o_rule.nxt.refs = 16'd0;
                o_rule.refs     = 16'd0;
            end
            orhp_pkg::CMD_TEARDOWN: begin
                o_rule.wr  = i_entry.live && match;
                o_rule.nxt = freed;
            end
            default: begin
                o_rule.status = orhp_pkg::ST_BAD_ARG;
            end
        endcase
    end

endmodule

>>> design/owned_refcounted_handle_pool.sv
// handle pool top: sequencer around one slot memory with clearing pass
// steps from accept to result valid: immediate answers go straight to done, single-slot
// commands read the slot then execute, allocate runs a pipelined scan of one pool,
// teardown a pipelined walk of the whole memory; all then wait in done for the output
// one item in flight; input is ready again in the same cycle its result becomes valid
// after reset a clearing pass that zeroes every slot holds off input
`include "owned_refcounted_handle_pool_defines.svh"
module owned_refcounted_handle_pool #(
    parameter int POOL_SLOTS = orhp_pkg::POOL_SLOTS_DEF,
    parameter int POOL_KINDS = orhp_pkg::POOL_KINDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  orhp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output orhp_pkg::t_out_item o_out_item
);

    localparam int TOTAL = POOL_SLOTS * POOL_KINDS;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int SW    = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CW    = $clog2(TOTAL + 1);

    // sequencer states
    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_EXE   = 3'd3;
    localparam logic [2:0] S_ALLOC = 3'd4;
    localparam logic [2:0] S_TEAR  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // slot memory: one entry per slot, all pools back to back
    orhp_pkg::t_slot r_mem [TOTAL];
    orhp_pkg::t_slot r_rd;

    logic [2:0]          r_state, n_state;
    orhp_pkg::t_in_item  r_in, n_in;
    logic [CW-1:0]       r_cnt, n_cnt;     // issue counter for scans and clearing
    logic [AW-1:0]       r_chk, n_chk;     // index whose read data is in r_rd
    logic                r_pv, n_pv;       // r_rd holds a scan read
    orhp_pkg::t_out_item r_pend, n_pend;   // result waiting for the output register
    logic                r_ovalid, n_ovalid;
    orhp_pkg::t_out_item r_out, n_out;

    logic            rd_en, wr_en;
    logic [AW-1:0]   rd_addr, wr_addr;
    orhp_pkg::t_slot wr_data;
    orhp_pkg::t_rule rule;
    logic [AW-1:0]   base;
    logic [AW-1:0]   hit_addr;
    logic            in_acc;
    logic            kind_bad, hnd_bad, arg_bad;

    orhp_rule u_rule (
        .i_command (r_in.command),
        .i_who     (r_in.owner_id),
        .i_gen     (r_in.owner_epoch),
        .i_entry   (r_rd),
        .o_rule    (rule)
    );

    // memory ports: registered read, single write
    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd <= r_mem[rd_addr];
        if (wr_en) r_mem[wr_addr] <= wr_data;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    // first entry of the selected pool, and the addressed slot
    assign base     = AW'(AW'(r_in.pool_kind) * AW'(POOL_SLOTS));
    assign hit_addr = base + AW'(SW'(r_in.handle[6:0]));

    // checks on the arriving item
    assign kind_bad = 4'(i_in_item.pool_kind) >= 4'(POOL_KINDS);
    assign hnd_bad  = i_in_item.handle[7] ||
                      ({1'b0, i_in_item.handle[6:0]} >= 8'(POOL_SLOTS));
    assign arg_bad  = (i_in_item.pool_kind == orhp_pkg::KIND_SEM && i_in_item.alloc_arg[31]) ||
                      (i_in_item.pool_kind == orhp_pkg::KIND_BARRIER &&
                       i_in_item.alloc_arg == 32'sd0);

    always_comb begin
        n_state  = r_state;
        n_in     = r_in;
        n_cnt    = r_cnt;
        n_chk    = r_chk;
        n_pv     = 1'b0;
        n_pend   = r_pend;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        rd_en    = 1'b0;
        rd_addr  = hit_addr;
        wr_en    = 1'b0;
        wr_addr  = hit_addr;
        wr_data  = rule.nxt;

        // output register drains independently of the sequencer
        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;

        case (r_state)
            S_CLR: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt[AW-1:0];
                wr_data = '0;
                n_cnt   = r_cnt + CW'(1);
                if (r_cnt == CW'(TOTAL - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_in   = i_in_item;
                    n_cnt  = '0;
                    n_pend = '0;
                    if (i_in_item.command == orhp_pkg::CMD_UNKNOWN) begin
                        n_pend.status = orhp_pkg::ST_BAD_ARG;
                        n_state       = S_DONE;
                    end else if (i_in_item.command == orhp_pkg::CMD_TEARDOWN) begin
                        n_state = S_TEAR;
                    end else if (kind_bad) begin
                        n_pend.status = orhp_pkg::ST_RANGE;
                        n_state       = S_DONE;
                    end else if (i_in_item.command == orhp_pkg::CMD_ALLOC) begin
                        if (arg_bad) begin
                            n_pend.status = orhp_pkg::ST_BAD_ARG;
                            n_state       = S_DONE;
                        end else begin
                            n_state = S_ALLOC;
                        end
                    end else if (hnd_bad) begin
                        n_pend.status = orhp_pkg::ST_RANGE;
                        n_state       = S_DONE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_state = S_EXE;
            end
            S_EXE: begin
                // read-modify-write of the addressed slot
                wr_en             = rule.wr;
                n_pend.status     = rule.status;
                n_pend.handle_out = 6'(r_in.handle[6:0]);
                n_pend.ref_count  = rule.refs;
                n_state           = S_DONE;
            end
            S_ALLOC: begin
                // issue one read per cycle, check the previous one
                if (r_cnt != CW'(POOL_SLOTS)) begin
                    rd_en   = 1'b1;
                    rd_addr = base + AW'(r_cnt);
                    n_cnt   = r_cnt + CW'(1);
                    n_chk   = AW'(r_cnt);
                    n_pv    = 1'b1;
                end
                if (r_pv) begin
                    if (rule.wr) begin
                        wr_en             = 1'b1;
                        wr_addr           = base + r_chk;
                        n_pend.status     = orhp_pkg::ST_OK;
                        n_pend.handle_out = 6'(SW'(r_chk));
                        n_pend.ref_count  = rule.refs;
                        n_state           = S_DONE;
                    end else if (r_chk == AW'(POOL_SLOTS - 1)) begin
                        n_pend.status = orhp_pkg::ST_FULL;
                        n_state       = S_DONE;
                    end
                end
            end
            S_TEAR: begin
                // walk every slot of every pool; write back only matches
                if (r_cnt != CW'(TOTAL)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_cnt[AW-1:0];
                    n_cnt   = r_cnt + CW'(1);
                    n_chk   = r_cnt[AW-1:0];
                    n_pv    = 1'b1;
                end
                if (r_pv) begin
                    wr_en   = rule.wr;
                    wr_addr = r_chk;
                    if (r_chk == AW'(TOTAL - 1)) n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_out    = r_pend;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_pv     <= n_pv;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_chk  <= n_chk;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    // memory is only written by the clearing pass or a command in progress
    `ORHP_ASSERT_NOW(a_wr_state, wr_en, (r_state == S_CLR || r_state == S_EXE || r_state == S_ALLOC || r_state == S_TEAR))
    // an accepted item always takes the sequencer out of idle in the next cycle
    `ORHP_ASSERT_NEXT(a_acc_busy, in_acc, (r_state != S_IDLE))
    // a claimed free slot always answers ok with a count of one
    `ORHP_ASSERT_NEXT(a_alloc_one, (r_state == S_ALLOC && r_pv && rule.wr), (r_pend.status == orhp_pkg::ST_OK && r_pend.ref_count == 16'd1))
    // a result enters the output register only when it is free or draining
    `ORHP_ASSERT_NOW(a_no_overwrite, (r_state == S_DONE && r_ovalid && !i_out_ready), (n_state == S_DONE))

endmodule

>>> tb/owned_refcounted_handle_pool_test.sv
// testbench for the owned refcounted handle pool: predictor, driver, monitor and result checks
module owned_refcounted_handle_pool_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = orhp_pkg::POOL_SLOTS_DEF;
    localparam int KINDS = orhp_pkg::POOL_KINDS_DEF;
    localparam int TOTAL = SLOTS * KINDS;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    orhp_pkg::t_in_item  in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    orhp_pkg::t_out_item out_item;

    // handshakes seen at the last rising edge
    logic in_took = 1'b0;
    logic out_took = 1'b0;

    owned_refcounted_handle_pool DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    always #5 i_clk = ~i_clk;

    // predicted slot memory, flat index kind*SLOTS+slot
    logic        pool_live [TOTAL];
    logic [15:0] pool_owner[TOTAL];
    logic [31:0] pool_gen  [TOTAL];
    logic [15:0] pool_refs [TOTAL];

    orhp_pkg::t_in_item  pending_cmds[$];
    orhp_pkg::t_out_item expected_answers[$];
    int        error_count = 0;
    int        checked_count = 0;
    int        status_seen[8];
    bit        stimulus_done = 1'b0;

    // live handles held by the stimulus so most commands hit real slots
    logic [2:0]  held_kind[$];
    logic [5:0]  held_slot[$];
    logic [15:0] held_who[$];
    logic [31:0] held_gen[$];

    function automatic bit owner_ok(int idx, logic [15:0] who, logic [31:0] gen);
        if (pool_owner[idx] == 16'd0 && who == 16'd0) return 1'b1;
        return who != 16'd0 && pool_owner[idx] == who && pool_gen[idx] == gen;
    endfunction

    function automatic orhp_pkg::t_out_item pool_answer(logic [2:0] st, logic [5:0] h,
                                                        logic [15:0] r);
        orhp_pkg::t_out_item a;
        a.status = st;
        a.handle_out = h;
        a.ref_count = r;
        return a;
    endfunction

    // applies one command to the predicted memory and returns its answer
    function automatic orhp_pkg::t_out_item apply_command(orhp_pkg::t_in_item c);
        int base;
        int idx;
        logic [7:0] hraw;
        hraw = c.handle;
        if (c.command == orhp_pkg::CMD_TEARDOWN) begin
            for (int i = 0; i < TOTAL; i++)
                if (pool_live[i] && owner_ok(i, c.owner_id, c.owner_epoch)) begin
                    pool_live[i] = 1'b0;
                    pool_owner[i] = '0;
                end
            return pool_answer(orhp_pkg::ST_OK, '0, '0);
        end
        if (c.command == orhp_pkg::CMD_UNKNOWN)
            return pool_answer(orhp_pkg::ST_BAD_ARG, '0, '0);
        if (c.pool_kind >= KINDS) return pool_answer(orhp_pkg::ST_RANGE, '0, '0);
        base = c.pool_kind * SLOTS;
        if (c.command == orhp_pkg::CMD_ALLOC) begin
            if (c.pool_kind == orhp_pkg::KIND_SEM && c.alloc_arg[31])
                return pool_answer(orhp_pkg::ST_BAD_ARG, '0, '0);
            if (c.pool_kind == orhp_pkg::KIND_BARRIER && c.alloc_arg == 0)
                return pool_answer(orhp_pkg::ST_BAD_ARG, '0, '0);
            for (int i = 0; i < SLOTS; i++) begin
                idx = base + i;
                if (!pool_live[idx]) begin
                    pool_live[idx] = 1'b1;
                    pool_owner[idx] = c.owner_id;
                    pool_gen[idx] = (c.owner_id != 0) ? c.owner_epoch : '0;
                    pool_refs[idx] = 16'd1;
                    return pool_answer(orhp_pkg::ST_OK, i[5:0], 16'd1);
                end
            end
            return pool_answer(orhp_pkg::ST_FULL, '0, '0);
        end
        if (hraw[7] || hraw >= SLOTS) return pool_answer(orhp_pkg::ST_RANGE, '0, '0);
        idx = base + hraw;
        if (c.command == orhp_pkg::CMD_FORCE) begin
            pool_live[idx] = 1'b0;
            pool_owner[idx] = '0;
            pool_refs[idx] = '0;
            return pool_answer(orhp_pkg::ST_OK, hraw[5:0], '0);
        end
        if (!pool_live[idx])
            return pool_answer(orhp_pkg::ST_NOT_LIVE, hraw[5:0], pool_refs[idx]);
        case (c.command)
            orhp_pkg::CMD_ADD_REF: begin
                if (pool_refs[idx] == orhp_pkg::REFS_MAX)
                    return pool_answer(orhp_pkg::ST_SATURATED, hraw[5:0], pool_refs[idx]);
                pool_refs[idx]++;
            end
            orhp_pkg::CMD_DROP_REF: begin
                if (pool_refs[idx] <= 1) begin
                    pool_refs[idx] = '0;
                    pool_live[idx] = 1'b0;
                    pool_owner[idx] = '0;
                end else begin
                    pool_refs[idx]--;
                end
            end
            orhp_pkg::CMD_OWN_REL: begin
                if (!owner_ok(idx, c.owner_id, c.owner_epoch))
                    return pool_answer(orhp_pkg::ST_NOT_OWNER, hraw[5:0], pool_refs[idx]);
                pool_live[idx] = 1'b0;
                pool_owner[idx] = '0;
            end
            default: ;
        endcase
        return pool_answer(orhp_pkg::ST_OK, hraw[5:0], pool_refs[idx]);
    endfunction

    function automatic orhp_pkg::t_in_item make_cmd(logic [2:0] cmd, logic [2:0] kind,
                                                    logic [7:0] h, logic [15:0] who,
                                                    logic [31:0] gen, logic [31:0] arg);
        orhp_pkg::t_in_item c;
        c.command = cmd;
        c.pool_kind = kind;
        c.handle = h;
        c.owner_id = who;
        c.owner_epoch = gen;
        c.alloc_arg = arg;
        return c;
    endfunction

    always @(posedge i_clk) begin
        in_took <= i_rst_n && in_valid && in_ready;
        out_took <= i_rst_n && out_valid && out_ready;
    end

    // driver: each item waits a random gap, then holds valid until taken
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (in_took) begin
            // taken at the last rising edge
            send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
            if (send_gap == 0 && pending_cmds.size() > 0) begin
                in_item <= pending_cmds.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end else if (!in_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_cmds.size() > 0) begin
                in_item <= pending_cmds.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // receiver stall, redrawn per result
    int recv_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (out_took) begin
            recv_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 11);
            out_ready <= (recv_gap == 0);
        end else if (recv_gap > 0) begin
            recv_gap--;
            out_ready <= (recv_gap == 0);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // monitor: predict on acceptance, check results in order
    always @(posedge i_clk) begin
        orhp_pkg::t_out_item want;
        if (i_rst_n && in_valid && in_ready)
            expected_answers.push_back(apply_command(in_item));
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected result expected none actual %p", $time, out_item);
                error_count++;
            end else begin
                want = expected_answers.pop_front();
                checked_count++;
                status_seen[out_item.status]++;
                if (out_item.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, out_item.status);
                if (out_item.handle_out !== want.handle_out)
                    $display("%0t: handle_out expected %0d actual %0d", $time,
                             want.handle_out, out_item.handle_out);
                if (out_item.ref_count !== want.ref_count)
                    $display("%0t: ref_count expected %0d actual %0d", $time,
                             want.ref_count, out_item.ref_count);
                if (out_item !== want) error_count++;
            end
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || in_valid || expected_answers.size() > 0)
            @(posedge i_clk);
    endtask

    // one random command, mostly aimed at slots the stimulus holds
    task automatic push_random();
        int pick;
        int n;
        logic [2:0] k;
        logic [15:0] who;
        logic [31:0] gen;
        logic [31:0] arg;
        logic [7:0] h;
        pick = $urandom_range(0, 99);
        n = held_kind.size();
        who = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
        gen = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 2));
        k = 3'($urandom_range(0, KINDS - 1));
        arg = $urandom;
        if ($urandom_range(0, 4) == 0) arg = 32'd0;
        if (pick < 5) begin
            // noise over every field value
            pending_cmds.push_back(make_cmd(3'($urandom), 3'($urandom), 8'($urandom),
                                            16'($urandom), $urandom, $urandom));
        end else if (pick < 35 || n == 0) begin
            pending_cmds.push_back(make_cmd(orhp_pkg::CMD_ALLOC, k, '0, who, gen, arg));
            if (!(k == orhp_pkg::KIND_SEM && arg[31]) &&
                !(k == orhp_pkg::KIND_BARRIER && arg == 0)) begin
                held_kind.push_back(k);
                held_who.push_back(who);
                held_gen.push_back(gen);
                held_slot.push_back('0);
            end
        end else if (pick < 38) begin
            pending_cmds.push_back(make_cmd(orhp_pkg::CMD_TEARDOWN, 3'($urandom),
                                            8'($urandom), who, gen, $urandom));
        end else begin
            n = $urandom_range(0, n - 1);
            k = held_kind[n];
            h = 8'($urandom_range(0, 15));
            if ($urandom_range(0, 9) == 0) h = 8'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                who = held_who[n];
                gen = held_gen[n];
            end
            pending_cmds.push_back(make_cmd(3'($urandom_range(0, 5)), k, h, who, gen,
                                            $urandom));
            if ($urandom_range(0, 30) == 0) begin
                held_kind.delete(n);
                held_who.delete(n);
                held_gen.delete(n);
                held_slot.delete(n);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < TOTAL; i++) begin
            pool_live[i] = 1'b0;
            pool_owner[i] = '0;
            pool_gen[i] = '0;
            pool_refs[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: range edges, every command, argument checks
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_LOOKUP, 3'd0, 8'd0, 16'd0, '0, '0));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_ALLOC, 3'd0, 8'd0, 16'd0,
                                        32'hFFFF_FFFF, '0));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_ALLOC, 3'd0, 8'd0, 16'hFFFF,
                                        32'hFFFF_FFFF, '0));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_ALLOC, orhp_pkg::KIND_SEM, 8'd0, 16'd5,
                                        32'd1, 32'h8000_0000));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_ALLOC, orhp_pkg::KIND_SEM, 8'd0, 16'd5,
                                        32'd1, 32'h7FFF_FFFF));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_ALLOC, orhp_pkg::KIND_BARRIER, 8'd0,
                                        16'd5, 32'd1, 32'd0));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_ALLOC, orhp_pkg::KIND_BARRIER, 8'd0,
                                        16'd5, 32'd1, 32'd1));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_ALLOC, 3'd7, 8'd0, 16'd5, 32'd1, 32'd1));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_LOOKUP, 3'd0, 8'h80, 16'd0, '0, '0));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_LOOKUP, 3'd0, 8'h7F, 16'd0, '0, '0));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_LOOKUP, 3'd0, 8'd63, 16'd0, '0, '0));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_LOOKUP, 3'd0, 8'd64, 16'd0, '0, '0));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_ADD_REF, 3'd0, 8'd1, 16'd0, '0, '0));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_OWN_REL, 3'd0, 8'd1, 16'hFFFF,
                                        32'd0, '0));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_OWN_REL, 3'd0, 8'd1, 16'hFFFF,
                                        32'hFFFF_FFFF, '0));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_OWN_REL, 3'd0, 8'd1, 16'd0, '0, '0));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_DROP_REF, 3'd0, 8'd0, 16'd0, '0, '0));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_DROP_REF, 3'd0, 8'd0, 16'd0, '0, '0));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_FORCE, 3'd4, 8'd9, 16'd0, '0, '0));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_UNKNOWN, 3'd0, 8'd0, 16'd0, '0, '0));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_TEARDOWN, 3'd7, 8'hFF, 16'd5,
                                        32'd1, '0));
        wait_drained();

        // kernel-owned slot in the condvar pool
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_ALLOC, 3'd1, 8'd0, 16'd0, '0, '0));
        wait_drained();
        // fill a pool completely and overflow it
        for (int i = 0; i < SLOTS + 2; i++)
            pending_cmds.push_back(make_cmd(orhp_pkg::CMD_ALLOC, 3'd4, 8'd0, 16'd7,
                                            32'd3, 32'd1));
        pending_cmds.push_back(make_cmd(orhp_pkg::CMD_TEARDOWN, 3'd0, 8'd0, 16'd7,
                                        32'd3, '0));
        wait_drained();

        // random part with a full drain in the middle
        for (int i = 0; i < 1900; i++) begin
            push_random();
            if (i == 950) wait_drained();
            while (pending_cmds.size() > 8) @(posedge i_clk);
        end
        wait_drained();
        repeat (TOTAL + 20) @(posedge i_clk);

        $display("checked %0d results: ok %0d range %0d not-live %0d full %0d",
                 checked_count, status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3]);
        $display("bad-arg %0d not-owner %0d saturated %0d", status_seen[4],
                 status_seen[5], status_seen[6]);
        if (error_count == 0 && expected_answers.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+design
design/orhp_pkg.sv
design/orhp_rule.sv
design/owned_refcounted_handle_pool.sv
tb/owned_refcounted_handle_pool_test.sv
